// ===== design/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types, codes and the crc-16 byte update for the frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_FIRST    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_REQUEST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_RESPONSE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_EVENT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH    = 3'd5;

   // frame status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CRCERR  = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_NODATA  = 3'd3;
   localparam logic [2:0] ST_TOOLONG = 3'd4;

   // frame type codes
   localparam logic [1:0] FT_REQUEST  = 2'd0;
   localparam logic [1:0] FT_RESPONSE = 2'd1;
   localparam logic [1:0] FT_EVENT    = 2'd2;

   // result kinds
   localparam logic RK_PAYLOAD = 1'b0;
   localparam logic RK_STATUS  = 1'b1;

   // input kinds
   localparam logic FN_BYTE = 1'b0;
   localparam logic FN_TICK = 1'b1;

   // crc-16/ccitt-false
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  frame_status;
      logic [1:0]  frame_type;
      logic [31:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  head_first_value;
      logic [7:0]  type_request_value;
      logic [7:0]  type_response_value;
      logic [7:0]  type_event_value;
      logic [31:0] timeout_ticks;
      logic [31:0] max_payload_length;
   } cfg_type;

   // classified item as it sits in the queue
   typedef struct packed {
      logic       is_tick;
      logic       is_head;
      logic       type_hit;
      logic [1:0] type_code;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_LEN,
      PH_DATA,
      PH_CRC
   } phase_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== design/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front
// accepts input transactions and classifies them against the header values
// ----------------------------------------------------------------------------
module cfp_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cfp_pkg::req_type         req_data,
   input  cfp_pkg::cfg_type         cfg,
   input  cfp_pkg::fifo_status_type q_stat,
   output logic                     q_push,
   output cfp_pkg::item_type        q_item
);

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      q_item.is_tick = (req_data.func == cfp_pkg::FN_TICK);
      q_item.is_head = (req_data.rx_byte == cfg.head_first_value);
      q_item.rx_byte = req_data.rx_byte;
      // request wins over response, response over event
      q_item.type_hit  = 1'b1;
      q_item.type_code = cfp_pkg::FT_REQUEST;
      if (req_data.rx_byte == cfg.type_request_value) begin
         q_item.type_code = cfp_pkg::FT_REQUEST;
      end else if (req_data.rx_byte == cfg.type_response_value) begin
         q_item.type_code = cfp_pkg::FT_RESPONSE;
      end else if (req_data.rx_byte == cfg.type_event_value) begin
         q_item.type_code = cfp_pkg::FT_EVENT;
      end else begin
         q_item.type_hit = 1'b0;
      end
   end

endmodule

// ===== design/cfp_fifo.sv =====
// ----------------------------------------------------------------------------
// cfp_fifo
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module cfp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cfp_pkg::item_type        push_item,
   input  logic                     pop,
   output cfp_pkg::item_type        head_item,
   output cfp_pkg::fifo_status_type stat
);

   localparam logic [cfp_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
      cfp_pkg::FIFO_CNT_W'(cfp_pkg::FIFO_DEPTH);

   cfp_pkg::item_type                 mem_ff [cfp_pkg::FIFO_DEPTH];
   logic [cfp_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cfp_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cfp_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   assign stat.full  = (count_ff == DEPTH_CNT);
   assign stat.empty = (count_ff == '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/cfp_back.sv =====
// ----------------------------------------------------------------------------
// cfp_back
// frame parser state machine with crc check and registered result stage
// ----------------------------------------------------------------------------
module cfp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cfp_pkg::cfg_type         cfg,
   input  cfp_pkg::item_type        item,
   input  cfp_pkg::fifo_status_type q_stat,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cfp_pkg::rsp_type         rsp_data
);

   cfp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         len_cnt_ff, len_cnt_in;
   logic [31:0]        len_ff, len_in;
   logic [31:0]        data_cnt_ff, data_cnt_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        rx_crc_ff, rx_crc_in;
   logic [1:0]         type_ff, type_in;
   logic               crc_cnt_ff, crc_cnt_in;
   logic [31:0]        idle_ff, idle_in;
   logic               seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cfp_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               emit;
   cfp_pkg::rsp_type   emit_data;
   logic [31:0]        idle_inc;
   logic [31:0]        len_shift;
   logic [31:0]        data_cnt_inc;
   logic [15:0]        rx_crc_shift;
   logic [15:0]        crc_next;

   assign q_pop     = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idle_inc     = (idle_ff == '1) ? idle_ff : idle_ff + 32'd1;
   assign len_shift    = {len_ff[23:0], item.rx_byte};
   assign data_cnt_inc = data_cnt_ff + 32'd1;
   assign rx_crc_shift = {rx_crc_ff[7:0], item.rx_byte};
   assign crc_next     = cfp_pkg::crc16_byte(crc_ff, item.rx_byte);

   always_comb begin
      phase_in    = phase_ff;
      len_cnt_in  = len_cnt_ff;
      len_in      = len_ff;
      data_cnt_in = data_cnt_ff;
      crc_in      = crc_ff;
      rx_crc_in   = rx_crc_ff;
      type_in     = type_ff;
      crc_cnt_in  = crc_cnt_ff;
      idle_in     = idle_ff;
      seen_in     = seen_ff;

      emit                     = 1'b0;
      emit_data.result_kind    = cfp_pkg::RK_STATUS;
      emit_data.payload_byte   = 8'h00;
      emit_data.frame_status   = cfp_pkg::ST_OK;
      emit_data.frame_type     = type_ff;
      emit_data.payload_length = len_ff;

      if (q_pop) begin
         if (item.is_tick) begin
            idle_in = idle_inc;
            if (idle_inc >= cfg.timeout_ticks) begin
               emit = 1'b1;
               emit_data.frame_status = seen_ff ? cfp_pkg::ST_TIMEOUT : cfp_pkg::ST_NODATA;
            end
         end else begin
            idle_in = '0;
            seen_in = 1'b1;
            case (phase_ff)
               cfp_pkg::PH_HUNT: begin
                  if (item.is_head) begin
                     crc_in   = cfp_pkg::crc16_byte(cfp_pkg::CRC_INIT, item.rx_byte);
                     phase_in = cfp_pkg::PH_TYPE;
                  end
               end
               cfp_pkg::PH_TYPE: begin
                  if (item.type_hit) begin
                     type_in  = item.type_code;
                     crc_in   = crc_next;
                     phase_in = cfp_pkg::PH_LEN;
                  end else begin
                     phase_in = cfp_pkg::PH_HUNT;
                     crc_in   = cfp_pkg::CRC_INIT;
                     type_in  = cfp_pkg::FT_REQUEST;
                  end
               end
               cfp_pkg::PH_LEN: begin
                  crc_in     = crc_next;
                  len_in     = len_shift;
                  len_cnt_in = len_cnt_ff + 2'd1;
                  if (len_cnt_ff == 2'd3) begin
                     len_cnt_in = 2'd0;
                     if (len_shift > cfg.max_payload_length) begin
                        emit = 1'b1;
                        emit_data.frame_status   = cfp_pkg::ST_TOOLONG;
                        emit_data.payload_length = len_shift;
                     end else if (len_shift == '0) begin
                        phase_in = cfp_pkg::PH_CRC;
                     end else begin
                        phase_in = cfp_pkg::PH_DATA;
                     end
                  end
               end
               cfp_pkg::PH_DATA: begin
                  crc_in      = crc_next;
                  data_cnt_in = data_cnt_inc;
                  // count stays below length while in data, so equality ends it
                  if (data_cnt_inc == len_ff) begin
                     phase_in = cfp_pkg::PH_CRC;
                  end
                  emit = 1'b1;
                  emit_data.result_kind  = cfp_pkg::RK_PAYLOAD;
                  emit_data.payload_byte = item.rx_byte;
               end
               cfp_pkg::PH_CRC: begin
                  rx_crc_in  = rx_crc_shift;
                  crc_cnt_in = 1'b1;
                  if (crc_cnt_ff) begin
                     emit = 1'b1;
                     emit_data.frame_status = (rx_crc_shift == crc_ff) ?
                                              cfp_pkg::ST_OK : cfp_pkg::ST_CRCERR;
                  end
               end
               default: begin
                  phase_in = cfp_pkg::PH_HUNT;
               end
            endcase
         end

         // any status ends the frame
         if (emit && (emit_data.result_kind == cfp_pkg::RK_STATUS)) begin
            phase_in    = cfp_pkg::PH_HUNT;
            len_cnt_in  = '0;
            len_in      = '0;
            data_cnt_in = '0;
            crc_in      = cfp_pkg::CRC_INIT;
            rx_crc_in   = '0;
            type_in     = cfp_pkg::FT_REQUEST;
            crc_cnt_in  = 1'b0;
            idle_in     = '0;
            seen_in     = 1'b0;
         end
      end

      // result register
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         rsp_valid_in = emit;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfp_pkg::PH_HUNT;
         len_cnt_ff   <= '0;
         len_ff       <= '0;
         data_cnt_ff  <= '0;
         crc_ff       <= cfp_pkg::CRC_INIT;
         rx_crc_ff    <= '0;
         type_ff      <= cfp_pkg::FT_REQUEST;
         crc_cnt_ff   <= 1'b0;
         idle_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_cnt_ff   <= len_cnt_in;
         len_ff       <= len_in;
         data_cnt_ff  <= data_cnt_in;
         crc_ff       <= crc_in;
         rx_crc_ff    <= rx_crc_in;
         type_ff      <= type_in;
         crc_cnt_ff   <= crc_cnt_in;
         idle_ff      <= idle_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/crc_checked_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_parser
// serial frame deframer with crc-16/ccitt-false check and idle timeout
// ----------------------------------------------------------------------------
// flow: an accepted transaction is written into the queue; the parser step then
//   pops it and writes its result into the result register that drives rsp_valid
// throughput: one transaction per cycle unless a held result stalls the parser
//   step (one table-free crc byte update and one 32-bit compare per item)
// reset: synchronous, active high; parser hunts for a header, queue and result
//   register empty, configuration back to its reset values; no clearing pass
// ----------------------------------------------------------------------------
module crc_checked_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions: received bytes and idle ticks
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cfp_pkg::req_type                    req_data,
   // result transactions: payload bytes and frame status
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cfp_pkg::rsp_type                    rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [cfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   cfp_pkg::cfg_type         cfg_ff, cfg_in;
   cfp_pkg::fifo_status_type q_stat;
   cfp_pkg::item_type        q_item;
   cfp_pkg::item_type        q_head;
   logic                     q_push;
   logic                     q_pop;

   // configuration registers, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cfp_pkg::CSR_HEAD_FIRST:    cfg_in.head_first_value    = csr_wdata[7:0];
            cfp_pkg::CSR_TYPE_REQUEST:  cfg_in.type_request_value  = csr_wdata[7:0];
            cfp_pkg::CSR_TYPE_RESPONSE: cfg_in.type_response_value = csr_wdata[7:0];
            cfp_pkg::CSR_TYPE_EVENT:    cfg_in.type_event_value    = csr_wdata[7:0];
            cfp_pkg::CSR_TIMEOUT:       cfg_in.timeout_ticks       = csr_wdata;
            cfp_pkg::CSR_MAX_LENGTH:    cfg_in.max_payload_length  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_first_value    <= 8'd0;
         cfg_ff.type_request_value  <= 8'd0;
         cfg_ff.type_response_value <= 8'd1;
         cfg_ff.type_event_value    <= 8'd2;
         cfg_ff.timeout_ticks       <= 32'd1000;
         cfg_ff.max_payload_length  <= 32'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   cfp_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   // queue between front and back
   cfp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (q_head),
      .stat      (q_stat)
   );

   // back: parse, check crc, drive results
   cfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // payload byte results never carry a status code
   a_payload_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == cfp_pkg::RK_PAYLOAD) |->
         rsp_data.frame_status == cfp_pkg::ST_OK)
      else $error("payload result with nonzero status");

   // status results carry a zero byte and a known code
   a_status_form : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == cfp_pkg::RK_STATUS) |->
         (rsp_data.payload_byte == 8'h00 &&
          (rsp_data.frame_status == cfp_pkg::ST_OK ||
           rsp_data.frame_status == cfp_pkg::ST_CRCERR ||
           rsp_data.frame_status == cfp_pkg::ST_TIMEOUT ||
           rsp_data.frame_status == cfp_pkg::ST_NODATA ||
           rsp_data.frame_status == cfp_pkg::ST_TOOLONG)))
      else $error("malformed status result");

   // a frame type is never the unused code
   a_frame_type : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frame_type != 2'd3)
      else $error("bad frame type");

   // coming out of reset the queue and result register are empty
   a_reset_empty : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (q_stat.empty && !rsp_valid))
      else $error("state left over after reset");

endmodule
